FILE: rtl/sdm_pkg.sv
package sdm_pkg;

   localparam int FIELD_BITS    = 16;
   localparam int BASE_BITS     = 17;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from paddr[2]
   localparam logic [0:0] REG_DIGIT_BASE = 1'b0;
   localparam logic [BASE_BITS-1:0] BASE_RESET = 17'd10;

   typedef struct packed {
      logic busy;
      logic clamp_hit;
   } mac_status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: rtl/sdm_operand_store.sv
module sdm_operand_store import sdm_pkg::*; #(
   parameter int MAX_DIGITS = 32,
   parameter int ADDR_BITS  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [FIELD_BITS-1:0] wr_a,
   input  logic [FIELD_BITS-1:0] wr_b,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr_a,
   input  logic [ADDR_BITS-1:0]  rd_addr_b,
   output logic                  rd_valid,
   output logic [FIELD_BITS-1:0] rd_a,
   output logic [FIELD_BITS-1:0] rd_b
);

   logic [FIELD_BITS-1:0] a_store_ff [MAX_DIGITS];
   logic [FIELD_BITS-1:0] b_store_ff [MAX_DIGITS];
   logic [FIELD_BITS-1:0] rd_a_ff;
   logic [FIELD_BITS-1:0] rd_b_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         a_store_ff[wr_addr] <= wr_a;
         b_store_ff[wr_addr] <= wr_b;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= a_store_ff[rd_addr_a];
         rd_b_ff <= b_store_ff[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_a     = rd_a_ff;
   assign rd_b     = rd_b_ff;

endmodule

FILE: rtl/sdm_mac.sv
module sdm_mac import sdm_pkg::*; #(
   parameter int DIGIT_BITS = 16,
   parameter int SUM_BITS   = 38
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  in_valid,
   input  logic [FIELD_BITS-1:0] in_a,
   input  logic [FIELD_BITS-1:0] in_b,
   input  logic [DIGIT_BITS:0]   base,
   output logic [SUM_BITS-1:0]   acc,
   output mac_status_type        status
);

   logic [DIGIT_BITS:0]     base_m1;
   logic                    a_hit;
   logic                    b_hit;
   logic [DIGIT_BITS-1:0]   a_sat;
   logic [DIGIT_BITS-1:0]   b_sat;
   logic [2*DIGIT_BITS-1:0] prod_ff;
   logic [2*DIGIT_BITS-1:0] prod_in;
   logic                    pvalid_ff;
   logic [SUM_BITS-1:0]     acc_ff;
   logic [SUM_BITS-1:0]     acc_in;

   always_comb begin
      base_m1 = base - (DIGIT_BITS+1)'(1);
      a_hit   = BASE_BITS'(in_a) >= BASE_BITS'(base);
      b_hit   = BASE_BITS'(in_b) >= BASE_BITS'(base);
      a_sat   = a_hit ? base_m1[DIGIT_BITS-1:0] : in_a[DIGIT_BITS-1:0];
      b_sat   = b_hit ? base_m1[DIGIT_BITS-1:0] : in_b[DIGIT_BITS-1:0];
      prod_in = a_sat * b_sat;
      if (clear) begin
         acc_in = '0;
      end else if (pvalid_ff) begin
         acc_in = acc_ff + SUM_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= in_valid;
      end
   end

   assign acc              = acc_ff;
   assign status.busy      = in_valid | pvalid_ff;
   assign status.clamp_hit = in_valid & (a_hit | b_hit);

endmodule

FILE: rtl/sdm_divider.sv
module sdm_divider import sdm_pkg::*; #(
   parameter int DIGIT_BITS = 16,
   parameter int SUM_BITS   = 38
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SUM_BITS-1:0]   dividend,
   input  logic [DIGIT_BITS:0]   divisor,
   output logic [SUM_BITS-1:0]   quotient,
   output logic [DIGIT_BITS-1:0] remainder,
   output div_status_type        status
);

   localparam int CNT_BITS = $clog2(SUM_BITS + 1);

   logic [SUM_BITS-1:0]   quo_ff;
   logic [SUM_BITS-1:0]   quo_in;
   logic [DIGIT_BITS-1:0] rem_ff;
   logic [DIGIT_BITS-1:0] rem_in;
   logic [DIGIT_BITS:0]   dsr_ff;
   logic [DIGIT_BITS:0]   trial;
   logic [DIGIT_BITS:0]   diff;
   logic                  ge;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_BITS-1]};
      ge     = trial >= dsr_ff;
      diff   = trial - dsr_ff;
      rem_in = ge ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
      quo_in = {quo_ff[SUM_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(SUM_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: rtl/schoolbook_digit_multiplier.sv
// channel | dir | handshake                     | payload
// req     | in  | req_tvalid / req_tready       | tdata {b_digit, a_digit}, tlast last_pair
// rsp     | out | rsp_tvalid / rsp_tready       | tdata product_digit, tlast is_last,
//         |     |                               | tuser {load_overflow, input_clamped}
// csr     | in  | psel, penable, pwrite, pready | digit_base at byte address 0
//
// A pair without tlast only loads the operand stores. The pair with tlast starts the product:
// each of the 2n-1 columns runs its c digit products through the shared multiplier, then the
// bit-serial divider (SUM_BITS = 38 by default) for the carry. Each product digit is then
// read from the product memory and held until rsp takes it. req_tready is low from the
// last pair until the last digit is taken. Synchronous reset; stores need no clearing.
module schoolbook_digit_multiplier import sdm_pkg::*; #(
   parameter int MAX_DIGITS = 32,
   parameter int DIGIT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [2*FIELD_BITS-1:0]  req_tdata,   // a_digit [15:0], b_digit [31:16]
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [FIELD_BITS-1:0]    rsp_tdata,   // product_digit [15:0]
   output logic                     rsp_tlast,
   output logic [1:0]               rsp_tuser,   // input_clamped [0], load_overflow [1]
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int ADDR_BITS = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_DIGITS + 1);
   localparam int PIDX_BITS = $clog2(2 * MAX_DIGITS);
   localparam int LEN_BITS  = CNT_BITS + 1;
   localparam int SUM_BITS  = 2 * DIGIT_BITS + $clog2(MAX_DIGITS) + 1;
   localparam logic [BASE_BITS-1:0] BASE_TOP = BASE_BITS'(2 ** DIGIT_BITS);

   localparam logic [2:0] ST_LOAD     = 3'd0;
   localparam logic [2:0] ST_COL      = 3'd1;
   localparam logic [2:0] ST_MAC      = 3'd2;
   localparam logic [2:0] ST_DRAIN    = 3'd3;
   localparam logic [2:0] ST_DIV      = 3'd4;
   localparam logic [2:0] ST_OUT_RD   = 3'd5;
   localparam logic [2:0] ST_OUT_SHOW = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [PIDX_BITS-1:0]  k_ff, k_in;
   logic [ADDR_BITS-1:0]  i_ff, i_in;
   logic [PIDX_BITS-1:0]  j_ff, j_in;
   logic [SUM_BITS-1:0]   carry_ff, carry_in;
   logic                  clamp_ff, clamp_in;
   logic                  ovf_ff, ovf_in;
   logic [BASE_BITS-1:0]  base_ff;
   logic [DIGIT_BITS-1:0] product_store_ff [2*MAX_DIGITS];
   logic [DIGIT_BITS-1:0] prod_q_ff;

   logic [DIGIT_BITS:0]   base_eff;
   logic                  req_fire;
   logic                  rsp_fire;
   logic                  store_wr;
   logic                  csr_wr;
   logic [LEN_BITS-1:0]   kx, nx, last_idx, two_n;
   logic [ADDR_BITS-1:0]  i_lo, i_hi, b_addr;
   logic                  rd_en;
   logic                  mac_clear;
   logic                  div_start;
   logic                  prod_wr;
   logic [SUM_BITS-1:0]   mac_acc;
   logic [SUM_BITS-1:0]   quotient;
   logic [DIGIT_BITS-1:0] remainder;
   logic                  rd_valid;
   logic [FIELD_BITS-1:0] rd_a, rd_b;
   mac_status_type        mac_st;
   div_status_type        div_st;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_DIGIT_BASE) begin
         base_ff <= csr_pwdata[BASE_BITS-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_DIGIT_BASE) ? CSR_DATA_BITS'(base_ff) : '0;

   always_comb begin
      if (base_ff < BASE_BITS'(2)) begin
         base_eff = (DIGIT_BITS+1)'(2);
      end else if (base_ff > BASE_TOP) begin
         base_eff = (DIGIT_BITS+1)'(BASE_TOP);
      end else begin
         base_eff = (DIGIT_BITS+1)'(base_ff);
      end
   end

   // column bounds: column k pairs a[i] with b[k-i]
   always_comb begin
      kx       = LEN_BITS'(k_ff);
      nx       = LEN_BITS'(count_ff);
      two_n    = {count_ff, 1'b0};
      last_idx = two_n - LEN_BITS'(1);
      i_lo     = (kx >= nx) ? ADDR_BITS'(kx - nx + LEN_BITS'(1)) : '0;
      i_hi     = (kx < nx) ? ADDR_BITS'(kx) : ADDR_BITS'(nx - LEN_BITS'(1));
      b_addr   = ADDR_BITS'(kx - LEN_BITS'(i_ff));
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid & req_tready;
   assign store_wr   = req_fire & (count_ff < CNT_BITS'(MAX_DIGITS));
   assign rsp_tvalid = (state_ff == ST_OUT_SHOW);
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign rd_en      = (state_ff == ST_MAC);
   assign mac_clear  = (state_ff == ST_COL);
   assign div_start  = (state_ff == ST_DRAIN) & ~mac_st.busy;
   assign prod_wr    = (state_ff == ST_DIV) & div_st.done;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      carry_in = carry_ff;
      clamp_in = clamp_ff | mac_st.clamp_hit;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (store_wr) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  k_in     = PIDX_BITS'({count_in, 1'b0} - LEN_BITS'(2));
                  carry_in = '0;
                  state_in = ST_COL;
               end
            end
         end
         ST_COL: begin
            i_in     = i_lo;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (i_ff == i_hi) begin
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff + ADDR_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (!mac_st.busy) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               carry_in = quotient;
               if (k_ff == '0) begin
                  j_in     = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  k_in     = k_ff - PIDX_BITS'(1);
                  state_in = ST_COL;
               end
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_SHOW;
         end
         ST_OUT_SHOW: begin
            if (rsp_fire) begin
               if (LEN_BITS'(j_ff) == last_idx) begin
                  count_in = '0;
                  clamp_in = 1'b0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  j_in     = j_ff + PIDX_BITS'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         clamp_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clamp_ff <= clamp_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      carry_ff <= carry_in;
   end

   // product digits, index 0 most significant; index 0 itself is the final carry
   always_ff @(posedge clock) begin
      if (prod_wr) begin
         product_store_ff[PIDX_BITS'(kx + LEN_BITS'(1))] <= remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT_RD) begin
         prod_q_ff <= product_store_ff[j_ff];
      end
   end

   assign rsp_tdata = (j_ff == '0) ? FIELD_BITS'(carry_ff[DIGIT_BITS-1:0])
                                   : FIELD_BITS'(prod_q_ff);
   assign rsp_tlast = (LEN_BITS'(j_ff) == last_idx);
   assign rsp_tuser = {ovf_ff, clamp_ff};

   sdm_operand_store #(
      .MAX_DIGITS (MAX_DIGITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (store_wr),
      .wr_addr   (ADDR_BITS'(count_ff)),
      .wr_a      (req_tdata[FIELD_BITS-1:0]),
      .wr_b      (req_tdata[2*FIELD_BITS-1:FIELD_BITS]),
      .rd_en     (rd_en),
      .rd_addr_a (i_ff),
      .rd_addr_b (b_addr),
      .rd_valid  (rd_valid),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   sdm_mac #(
      .DIGIT_BITS (DIGIT_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (mac_clear),
      .in_valid (rd_valid),
      .in_a     (rd_a),
      .in_b     (rd_b),
      .base     (base_eff),
      .acc      (mac_acc),
      .status   (mac_st)
   );

   sdm_divider #(
      .DIGIT_BITS (DIGIT_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mac_acc + carry_ff),
      .divisor   (base_eff),
      .quotient  (quotient),
      .remainder (remainder),
      .status    (div_st)
   );

endmodule

FILE: rtl/sdm_checker.sv
module sdm_checker import sdm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    req_tlast,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [FIELD_BITS-1:0]   rsp_tdata,
   input logic                    rsp_tlast,
   input logic [1:0]              rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready and valid together");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("ready after last pair");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled item changed");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("not back to loading after last digit");

endmodule

bind schoolbook_digit_multiplier sdm_checker u_sdm_checker (.*);

FILE: sim/schoolbook_digit_multiplier_tb.sv
`timescale 1ns / 100ps

module schoolbook_digit_multiplier_tb;
   import sdm_pkg::*;

   localparam int MAX_DIGITS  = 32;
   localparam int DIGIT_BITS  = 16;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS = 130;
   localparam logic [CSR_ADDR_BITS-1:0] BASE_ADDR  = {REG_DIGIT_BASE, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = {~REG_DIGIT_BASE, 2'b00};
   localparam int TOP_BASE = 1 << DIGIT_BITS;

   typedef struct {
      logic [FIELD_BITS-1:0] a;
      logic [FIELD_BITS-1:0] b;
      logic                  last;
   } pair_type;

   typedef struct {
      logic [FIELD_BITS-1:0] digit;
      logic                  last;
      logic                  clamped;
      logic                  overflow;
   } digit_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [2*FIELD_BITS-1:0]  req_tdata = '0;   // a_digit [15:0], b_digit [31:16]
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [FIELD_BITS-1:0]    rsp_tdata;        // product_digit [15:0]
   logic                     rsp_tlast;
   logic [1:0]               rsp_tuser;        // input_clamped [0], load_overflow [1]
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // predictor state
   logic [BASE_BITS-1:0]  base_reg = BASE_RESET;
   logic [FIELD_BITS-1:0] a_held [MAX_DIGITS];
   logic [FIELD_BITS-1:0] b_held [MAX_DIGITS];
   int                    held_count = 0;
   bit                    dropped_pair = 1'b0;

   pair_type  pair_q [$];
   digit_type product_q [$];
   pair_type  cur_pair = '{a: '0, b: '0, last: 1'b0};
   digit_type want;
   int     errors = 0;
   int     req_gap = 0;
   int     rsp_gap = 0;
   int     hold_left = 0;
   bit     arm_hold = 1'b0;
   bit     no_gaps = 1'b0;
   bit     next_valid;
   int     idle_cycles = 0;
   int     random_items = 0;

   schoolbook_digit_multiplier #(
      .MAX_DIGITS(MAX_DIGITS),
      .DIGIT_BITS(DIGIT_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   function automatic int unsigned clipped_base(logic [BASE_BITS-1:0] r);
      if (r < 2) return 2;
      if (r > TOP_BASE) return TOP_BASE;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // load one pair; on the final pair form the product and queue its digits
   function automatic void absorb_pair(pair_type p);
      int unsigned      eff;
      int               n;
      logic [FIELD_BITS-1:0] av [MAX_DIGITS];
      logic [FIELD_BITS-1:0] bv [MAX_DIGITS];
      logic [FIELD_BITS-1:0] digits [2*MAX_DIGITS];
      longint unsigned  col;
      longint unsigned  t;
      longint unsigned  carry;
      bit               clamped;
      digit_type        d;
      if (held_count < MAX_DIGITS) begin
         a_held[held_count] = p.a;
         b_held[held_count] = p.b;
         held_count++;
      end else begin
         dropped_pair = 1'b1;
      end
      if (!p.last) return;
      eff = clipped_base(base_reg);
      n = held_count;
      clamped = 1'b0;
      for (int i = 0; i < n; i++) begin
         av[i] = a_held[i];
         bv[i] = b_held[i];
         if (a_held[i] >= eff) begin
            av[i] = FIELD_BITS'(eff - 1);
            clamped = 1'b1;
         end
         if (b_held[i] >= eff) begin
            bv[i] = FIELD_BITS'(eff - 1);
            clamped = 1'b1;
         end
      end
      carry = 0;
      for (int k = 2*n - 2; k >= 0; k--) begin
         col = 0;
         for (int i = 0; i < n; i++) begin
            if (k >= i && k - i < n)
               col += 64'(av[i]) * 64'(bv[k-i]);
         end
         t = col + carry;
         carry = t / eff;
         digits[k+1] = FIELD_BITS'(t - carry * eff);
      end
      digits[0] = FIELD_BITS'(carry);
      for (int k = 0; k < 2*n; k++) begin
         d.digit = digits[k];
         d.last = (k == 2*n - 1);
         d.clamped = clamped;
         d.overflow = dropped_pair;
         product_q.push_back(d);
      end
      held_count = 0;
      dropped_pair = 1'b0;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_pair(cur_pair);
         next_valid = req_tvalid && !req_tready;
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pair_q.size() > 0) begin
               cur_pair = pair_q.pop_front();
               next_valid = 1'b1;
               req_gap = pick_gap();
            end
         end
         req_tvalid <= next_valid;
         req_tdata <= {cur_pair.b, cur_pair.a};
         req_tlast <= cur_pair.last;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (product_q.size() == 0) begin
               $display("%0t: unexpected digit %h last %b user %b", $time, rsp_tdata,
                        rsp_tlast, rsp_tuser);
               errors++;
            end else begin
               want = product_q.pop_front();
               if (rsp_tdata !== want.digit) begin
                  $display("%0t: product_digit expected %h actual %h", $time, want.digit,
                           rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: is_last expected %b actual %b", $time, want.last, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser[0] !== want.clamped) begin
                  $display("%0t: input_clamped expected %b actual %b", $time, want.clamped,
                           rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tuser[1] !== want.overflow) begin
                  $display("%0t: load_overflow expected %b actual %b", $time, want.overflow,
                           rsp_tuser[1]);
                  errors++;
               end
            end
            rsp_gap = pick_gap();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (arm_hold && rsp_tvalid) begin
            arm_hold = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr, input int unsigned value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == BASE_ADDR)
         base_reg = BASE_BITS'(value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      while (pair_q.size() > 0 || req_tvalid || next_valid || product_q.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic send_pair(input int unsigned a, input int unsigned b, input bit last);
      pair_type p;
      p.a = FIELD_BITS'(a);
      p.b = FIELD_BITS'(b);
      p.last = last;
      pair_q.push_back(p);
   endtask

   function automatic int unsigned pick_digit();
      int unsigned eff;
      int          roll;
      eff = clipped_base(base_reg);
      roll = $urandom_range(0, 9);
      if (roll < 6) return $urandom_range(0, eff - 1);
      if (roll == 6) return 0;
      if (roll == 7) return eff - 1;
      return $urandom_range(0, TOP_BASE - 1);
   endfunction

   task automatic send_number(input int len);
      for (int i = 0; i < len; i++)
         send_pair(pick_digit(), pick_digit(), i == len - 1);
      random_items += len;
   endtask

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 68) return $urandom_range(1, 6);
      if (roll < 88) return $urandom_range(7, 16);
      if (roll < 95) return MAX_DIGITS;
      return $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
   endfunction

   initial begin
      int unsigned base_pick;
      int          phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset base of ten
      send_pair(9, 9, 1'b1);
      send_pair(12, 3, 1'b1);
      send_pair(9, 9, 1'b0);
      send_pair(9, 9, 1'b1);
      drain();
      csr_write(BASE_ADDR, TOP_BASE);
      send_pair(16'hffff, 16'hffff, 1'b1);
      send_pair(0, 0, 1'b1);
      send_pair(16'h8000, 16'h7fff, 1'b0);
      send_pair(16'h5555, 16'haaaa, 1'b1);
      drain();
      csr_write(BASE_ADDR, 0);
      send_pair(1, 1, 1'b0);
      send_pair(16'hffff, 0, 1'b1);
      drain();
      csr_write(BASE_ADDR, 1);
      send_pair(1, 0, 1'b1);
      drain();
      csr_write(BASE_ADDR, 32'h1ffff);
      send_pair(16'hffff, 1, 1'b1);
      drain();
      // other index must leave the base alone
      csr_write(SPARE_ADDR, 3);
      send_pair(16'hfffe, 16'hffff, 1'b1);
      drain();

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: base_pick = 2;
            1: base_pick = 10;
            2: base_pick = TOP_BASE;
            3: base_pick = TOP_BASE - 1;
            4: base_pick = $urandom_range(0, 1);
            5: base_pick = $urandom_range(TOP_BASE + 1, (1 << BASE_BITS) - 1);
            default: base_pick = $urandom_range(2, TOP_BASE);
         endcase
         csr_write(BASE_ADDR, base_pick);
         no_gaps = (phase % 3 == 1);
         if (phase == 0) begin
            arm_hold = 1'b1;
            send_number(8);
         end
         repeat ($urandom_range(2, 4))
            send_number(pick_length());
         drain();
         phase++;
      end

      while (pair_q.size() > 0 || req_tvalid || next_valid || product_q.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sdm_pkg.sv
rtl/sdm_operand_store.sv
rtl/sdm_mac.sv
rtl/sdm_divider.sv
rtl/schoolbook_digit_multiplier.sv
rtl/sdm_checker.sv
sim/schoolbook_digit_multiplier_tb.sv
